// ===== sv/cubic_bezier_flattener_defines.svh =====
// Assertion macros for the flattener RTL.
`ifndef CUBIC_BEZIER_FLATTENER_DEFINES_SVH
`define CUBIC_BEZIER_FLATTENER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define CBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cbf_pkg.sv =====
// Shared types, widths and constants of the cubic Bezier flattener.
package cbf_pkg;

  // Segment count limits
  localparam int MAX_SEGMENTS = 32;
  localparam int MIN_SEGMENTS = 4;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Compare width for tolerance * MAX_SEGMENTS against the polygon length
  localparam int CMP_W = 48;

  // Command kinds
  typedef enum logic [1:0] {
    CMD_FIRST = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CUBIC = 2'd2,
    CMD_MOVE  = 2'd3
  } cmd_kind_t;

  // Configuration register indexes
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_CLOSE     = 1'b1;

  // Shared multiply-accumulate unit
  localparam int MAC_A_W = 35;
  localparam int MAC_B_W = 33;
  localparam int ACC_W   = 70;

  typedef struct packed {
    logic                       en;
    logic                       clr;
    logic                       shl;
    logic signed [MAC_A_W-1:0]  a;
    logic signed [MAC_B_W-1:0]  b;
  } mac_op_t;

  // Iterative root / divide unit
  localparam int RD_SRC_W  = 68;
  localparam int RD_Q_W    = 36;
  localparam int RD_R_W    = 38;
  localparam int ROOT_ITER = 34;
  localparam int DIV_ITER  = 36;
  localparam int RD_CNT_W  = 6;

  typedef struct packed {
    logic                start;
    logic                is_root;
    logic [RD_SRC_W-1:0] src;
    logic [RD_Q_W-1:0]   dvsr;
  } rd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

endpackage

// ===== sv/cbf_mac.sv =====
// Shared signed multiply-accumulate unit with optional 17-bit product shift.
module cbf_mac (
  input  logic                                clk,
  input  cbf_pkg::mac_op_t                    op,
  output logic signed [cbf_pkg::ACC_W-1:0]    acc
);

  logic signed [cbf_pkg::MAC_A_W+cbf_pkg::MAC_B_W-1:0] prod;
  logic signed [cbf_pkg::ACC_W-1:0] prod_ext;
  logic signed [cbf_pkg::ACC_W-1:0] prod_sh;
  logic signed [cbf_pkg::ACC_W-1:0] base;

  // Product, sign extended and optionally moved up by 17 bits
  always_comb begin
    prod     = op.a * op.b;
    prod_ext = cbf_pkg::ACC_W'(prod);
    prod_sh  = op.shl ? (prod_ext <<< 17) : prod_ext;
    base     = op.clr ? '0 : acc;
  end

  // Accumulator register
  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + prod_sh;
    end
  end

endmodule

// ===== sv/cbf_rootdiv.sv =====
// Iterative restoring square root / divider, one result bit per cycle.
module cbf_rootdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  cbf_pkg::rd_cmd_t              cmd,
  output cbf_pkg::rd_stat_t             stat,
  output logic [cbf_pkg::RD_Q_W-1:0]    q,
  output logic [cbf_pkg::RD_R_W-1:0]    rem
);

  logic [cbf_pkg::RD_SRC_W-1:0] src;
  logic [cbf_pkg::RD_Q_W-1:0]   dvsr;
  logic [cbf_pkg::RD_CNT_W-1:0] cnt;
  logic                         is_root;
  logic [cbf_pkg::RD_R_W-1:0]   rem_sh;
  logic [cbf_pkg::RD_R_W-1:0]   trial;
  logic                         ge;

  // One step: shift in bits, compare against trial value
  always_comb begin
    if (is_root) begin
      rem_sh = {rem[cbf_pkg::RD_R_W-3:0], src[cbf_pkg::RD_SRC_W-1 -: 2]};
      trial  = {q, 2'b01};
    end else begin
      rem_sh = {rem[cbf_pkg::RD_R_W-2:0], src[cbf_pkg::RD_SRC_W-1]};
      trial  = {2'b00, dvsr};
    end
    ge = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (cmd.start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && cnt == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src     <= cmd.src;
      dvsr    <= cmd.dvsr;
      is_root <= cmd.is_root;
      q       <= '0;
      rem     <= '0;
      cnt     <= cmd.is_root ? cbf_pkg::RD_CNT_W'(cbf_pkg::ROOT_ITER - 1)
                             : cbf_pkg::RD_CNT_W'(cbf_pkg::DIV_ITER - 1);
    end else if (stat.busy) begin
      src <= is_root ? (src << 2) : (src << 1);
      rem <= ge ? (rem_sh - trial) : rem_sh;
      q   <= {q[cbf_pkg::RD_Q_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== sv/cubic_bezier_flattener.sv =====
// Top level: command sequencer, shared units and point output stage.
//
//  channel   | direction | accept             | payload
//  s_axis    | in        | tvalid & tready    | tdata 6 coordinates, tuser kind, tlast path end
//  m_axis    | out       | tvalid & tready    | tdata point x/y, tuser closing, tlast run end
//  cfg       | in        | cfg_we             | cfg_index, cfg_data
//
// A cubic finds its segment count through the one root/divide unit (three roots
// and a divide, skipped when the count is capped at the maximum), then for each
// segment runs a divide for t, weights and blending on the shared MAC, and puts
// the point if it differs from the last point emitted.
// Reset is synchronous; it clears the sequencer, the path state and the
// registers to their reset values. A stalled output holds the sequencer at its
// next point; s_axis_tready is high only when the block is idle.
`include "cubic_bezier_flattener_defines.svh"

module cubic_bezier_flattener (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
  input  logic [1:0]   s_axis_tuser,  // command_kind
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // point_x, point_y
  output logic [0:0]   m_axis_tuser,  // closing_point
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_EMIT  = 11'b000_0000_0010,
    ST_EDGE  = 11'b000_0000_0100,
    ST_ROOT  = 11'b000_0000_1000,
    ST_CDIV  = 11'b000_0001_0000,
    ST_TDIV  = 11'b000_0010_0000,
    ST_WGT   = 11'b000_0100_0000,
    ST_BLEND = 11'b000_1000_0000,
    ST_CPUT  = 11'b001_0000_0000,
    ST_CLOSE = 11'b010_0000_0000,
    ST_FLUSH = 11'b100_0000_0000
  } state_t;

  state_t state;
  logic [3:0] step;

  // Command and path state
  cbf_pkg::cmd_kind_t kind;
  logic signed [31:0] end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y;
  logic               path_end;
  logic signed [31:0] current_x, current_y, first_x, first_y;
  logic signed [31:0] last_emitted_x, last_emitted_y;
  logic [30:0]        seg_tol;
  logic               close_path;

  // Curve working registers
  logic [1:0]                 edge_idx;
  logic [35:0]                poly_len;
  logic [cbf_pkg::CNT_W-1:0]  seg_n, seg_s;
  logic [16:0]                t_val;
  logic [33:0]                uu, tt;
  logic [30:0]                w [4];
  logic signed [31:0]         px, py;

  // Pending point and output register
  logic               pend_valid, pend_close;
  logic signed [31:0] pend_x, pend_y;
  logic               out_valid, out_last, out_close;
  logic signed [31:0] out_x, out_y;

  // Shared units
  cbf_pkg::mac_op_t                  mac_op;
  logic signed [cbf_pkg::ACC_W-1:0]  acc;
  cbf_pkg::rd_cmd_t                  rd_cmd;
  cbf_pkg::rd_stat_t                 rd_stat;
  logic [cbf_pkg::RD_Q_W-1:0]        rd_q;
  logic [cbf_pkg::RD_R_W-1:0]        rd_rem;

  cbf_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  cbf_rootdiv u_rootdiv (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rd_cmd),
    .stat (rd_stat),
    .q    (rd_q),
    .rem  (rd_rem)
  );

  // Rounded Bernstein weight: (k * raw + 2^17) >> 18, k is 1 or 3
  function automatic logic [30:0] round_w(input logic [48:0] raw, input logic triple);
    logic [49:0] v;
    v = triple ? ({1'b0, raw} + {raw, 1'b0}) : {1'b0, raw};
    v = v + 50'(1 << 17);
    return v[48:18];
  endfunction

  // Blend sum to Q16.16: round half up by 2^30, saturate
  function automatic logic signed [31:0] round_pt(input logic signed [69:0] sum);
    logic signed [69:0] v;
    v = (sum + 70'sd536870912) >>> 30;
    if (v > 70'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -70'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  // Edge endpoints for the control polygon
  logic signed [31:0] ea_x, ea_y, eb_x, eb_y;
  logic signed [32:0] dx_s, dy_s;
  logic [32:0]        dx_m, dy_m;

  always_comb begin
    unique case (edge_idx)
      2'd0: begin
        ea_x = current_x; ea_y = current_y; eb_x = ctrl1_x; eb_y = ctrl1_y;
      end
      2'd1: begin
        ea_x = ctrl1_x; ea_y = ctrl1_y; eb_x = ctrl2_x; eb_y = ctrl2_y;
      end
      default: begin
        ea_x = ctrl2_x; ea_y = ctrl2_y; eb_x = end_x; eb_y = end_y;
      end
    endcase
    dx_s = 33'(eb_x) - 33'(ea_x);
    dy_s = 33'(eb_y) - 33'(ea_y);
    dx_m = dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
    dy_m = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
  end

  // Parameter values and blend operands
  logic [16:0]        u_val;
  logic signed [31:0] blend_pt;
  logic [30:0]        blend_w;

  always_comb begin
    u_val   = 17'h1_0000 - t_val;
    blend_w = w[step[1:0]];
    unique case (step[1:0])
      2'd0:    blend_pt = step[2] ? current_y : current_x;
      2'd1:    blend_pt = step[2] ? ctrl1_y   : ctrl1_x;
      2'd2:    blend_pt = step[2] ? ctrl2_y   : ctrl2_x;
      default: blend_pt = step[2] ? end_y     : end_x;
    endcase
  end

  // MAC operation schedule
  always_comb begin
    mac_op = '0;
    if (state == ST_EDGE && step < 4'd4) begin
      mac_op.en  = 1'b1;
      mac_op.clr = (step == 4'd0);
      mac_op.shl = step[0];
      mac_op.a   = step[1] ? cbf_pkg::MAC_A_W'(dy_m) : cbf_pkg::MAC_A_W'(dx_m);
      unique case (step[1:0])
        2'd0:    mac_op.b = cbf_pkg::MAC_B_W'(dx_m[16:0]);
        2'd1:    mac_op.b = cbf_pkg::MAC_B_W'(dx_m[32:17]);
        2'd2:    mac_op.b = cbf_pkg::MAC_B_W'(dy_m[16:0]);
        default: mac_op.b = cbf_pkg::MAC_B_W'(dy_m[32:17]);
      endcase
    end else if (state == ST_WGT && step < 4'd6) begin
      mac_op.en  = 1'b1;
      mac_op.clr = 1'b1;
      unique case (step[2:0])
        3'd0: begin
          mac_op.a = cbf_pkg::MAC_A_W'(u_val); mac_op.b = cbf_pkg::MAC_B_W'(u_val);
        end
        3'd1: begin
          mac_op.a = cbf_pkg::MAC_A_W'(t_val); mac_op.b = cbf_pkg::MAC_B_W'(t_val);
        end
        3'd2: begin
          mac_op.a = cbf_pkg::MAC_A_W'(uu); mac_op.b = cbf_pkg::MAC_B_W'(u_val);
        end
        3'd3: begin
          mac_op.a = cbf_pkg::MAC_A_W'(uu); mac_op.b = cbf_pkg::MAC_B_W'(t_val);
        end
        3'd4: begin
          mac_op.a = cbf_pkg::MAC_A_W'(tt); mac_op.b = cbf_pkg::MAC_B_W'(u_val);
        end
        default: begin
          mac_op.a = cbf_pkg::MAC_A_W'(tt); mac_op.b = cbf_pkg::MAC_B_W'(t_val);
        end
      endcase
    end else if (state == ST_BLEND && step < 4'd8) begin
      mac_op.en  = 1'b1;
      mac_op.clr = (step[1:0] == 2'd0);
      mac_op.a   = cbf_pkg::MAC_A_W'(blend_pt);
      mac_op.b   = cbf_pkg::MAC_B_W'(blend_w);
    end
  end

  // Root / divide commands
  logic [cbf_pkg::CMP_W-1:0] tol_max;
  logic [35:0]               t_dividend;

  always_comb begin
    tol_max    = cbf_pkg::CMP_W'(seg_tol) * cbf_pkg::CMP_W'(cbf_pkg::MAX_SEGMENTS);
    t_dividend = (36'(seg_s) << 16) + 36'(seg_n >> 1);
    rd_cmd     = '0;
    if (state == ST_EDGE && step == 4'd4) begin
      rd_cmd.start   = 1'b1;
      rd_cmd.is_root = 1'b1;
      rd_cmd.src     = acc[cbf_pkg::RD_SRC_W-1:0];
    end else if (state == ST_CDIV && step == 4'd0 && seg_tol != '0
                 && cbf_pkg::CMP_W'(poly_len) < tol_max) begin
      rd_cmd.start = 1'b1;
      rd_cmd.src   = {poly_len, 32'b0};
      rd_cmd.dvsr  = cbf_pkg::RD_Q_W'(seg_tol);
    end else if (state == ST_TDIV && step == 4'd0) begin
      rd_cmd.start = 1'b1;
      rd_cmd.src   = {t_dividend, 32'b0};
      rd_cmd.dvsr  = cbf_pkg::RD_Q_W'(seg_n);
    end
  end

  // Point emission requests
  logic               out_free, put_ok, do_put, do_flush, differs, close_due;
  logic signed [31:0] put_x, put_y;
  logic               put_close;
  logic [cbf_pkg::CNT_W-1:0] n_ceil;

  always_comb begin
    out_free  = !out_valid || m_axis_tready;
    put_ok    = !pend_valid || out_free;
    differs   = (px != last_emitted_x) || (py != last_emitted_y);
    close_due = path_end && close_path;
    do_put    = 1'b0;
    put_x     = end_x;
    put_y     = end_y;
    put_close = 1'b0;
    n_ceil    = rd_q[cbf_pkg::CNT_W-1:0] + cbf_pkg::CNT_W'(rd_rem != '0);
    if (state == ST_EMIT) begin
      do_put = put_ok;
    end else if (state == ST_CPUT) begin
      do_put = put_ok && differs;
      put_x  = px;
      put_y  = py;
    end else if (state == ST_CLOSE) begin
      do_put    = put_ok && close_due;
      put_x     = first_x;
      put_y     = first_y;
      put_close = 1'b1;
    end
    do_flush = (state == ST_FLUSH) && pend_valid && out_free;
  end

  // Sequencer and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      step            <= '0;
      seg_tol         <= 31'd65536;
      close_path      <= 1'b0;
      current_x       <= '0;
      current_y       <= '0;
      first_x         <= '0;
      first_y         <= '0;
      last_emitted_x  <= '0;
      last_emitted_y  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cbf_pkg::REG_TOLERANCE: seg_tol    <= cfg_data;
          cbf_pkg::REG_CLOSE:     close_path <= cfg_data[0];
        endcase
      end
      if (do_put) begin
        last_emitted_x <= put_x;
        last_emitted_y <= put_y;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind     <= cbf_pkg::cmd_kind_t'(s_axis_tuser);
            end_x    <= s_axis_tdata[31:0];
            end_y    <= s_axis_tdata[63:32];
            ctrl1_x  <= s_axis_tdata[95:64];
            ctrl1_y  <= s_axis_tdata[127:96];
            ctrl2_x  <= s_axis_tdata[159:128];
            ctrl2_y  <= s_axis_tdata[191:160];
            path_end <= s_axis_tlast;
            step     <= '0;
            edge_idx <= '0;
            poly_len <= '0;
            unique case (cbf_pkg::cmd_kind_t'(s_axis_tuser))
              cbf_pkg::CMD_FIRST, cbf_pkg::CMD_LINE: state <= ST_EMIT;
              cbf_pkg::CMD_CUBIC:                    state <= ST_EDGE;
              default:                               state <= ST_CLOSE;
            endcase
          end
        end
        ST_EMIT: begin
          if (put_ok) begin
            if (kind == cbf_pkg::CMD_FIRST) begin
              first_x <= end_x;
              first_y <= end_y;
            end
            state <= ST_CLOSE;
          end
        end
        ST_EDGE: begin
          if (step == 4'd4) begin
            state <= ST_ROOT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_ROOT: begin
          if (rd_stat.done) begin
            poly_len <= poly_len + rd_q;
            if (edge_idx == 2'd2) begin
              state <= ST_CDIV;
            end else begin
              edge_idx <= edge_idx + 1'b1;
              state    <= ST_EDGE;
            end
            step <= '0;
          end
        end
        ST_CDIV: begin
          if (step == 4'd0) begin
            if (rd_cmd.start) begin
              step <= 4'd1;
            end else begin
              seg_n <= cbf_pkg::CNT_W'(cbf_pkg::MAX_SEGMENTS);
              seg_s <= cbf_pkg::CNT_W'(1);
              state <= ST_TDIV;
            end
          end else if (rd_stat.done) begin
            seg_n <= (n_ceil < cbf_pkg::CNT_W'(cbf_pkg::MIN_SEGMENTS))
                     ? cbf_pkg::CNT_W'(cbf_pkg::MIN_SEGMENTS) : n_ceil;
            seg_s <= cbf_pkg::CNT_W'(1);
            step  <= '0;
            state <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (rd_stat.done) begin
            t_val <= rd_q[16:0];
            step  <= '0;
            state <= ST_WGT;
          end
        end
        ST_WGT: begin
          unique case (step[2:0])
            3'd1:    uu   <= acc[33:0];
            3'd2:    tt   <= acc[33:0];
            3'd3:    w[0] <= round_w(acc[48:0], 1'b0);
            3'd4:    w[1] <= round_w(acc[48:0], 1'b1);
            3'd5:    w[2] <= round_w(acc[48:0], 1'b1);
            3'd6:    w[3] <= round_w(acc[48:0], 1'b0);
            default: ;
          endcase
          if (step == 4'd6) begin
            step  <= '0;
            state <= ST_BLEND;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_BLEND: begin
          if (step == 4'd4) px <= round_pt(acc);
          if (step == 4'd8) begin
            py    <= round_pt(acc);
            step  <= '0;
            state <= ST_CPUT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_CPUT: begin
          if (put_ok || !differs) begin
            if (seg_s == seg_n) begin
              state <= ST_CLOSE;
            end else begin
              seg_s <= seg_s + 1'b1;
              state <= ST_TDIV;
            end
          end
        end
        ST_CLOSE: begin
          if (put_ok || !close_due) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) begin
            current_x <= end_x;
            current_y <= end_y;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pending point and output register: a point goes out once the next one
  // is known, so the final point of a command can carry the run end mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((do_put && pend_valid) || do_flush) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (do_put) begin
        if (pend_valid) begin
          out_x     <= pend_x;
          out_y     <= pend_y;
          out_close <= pend_close;
          out_last  <= 1'b0;
        end
        pend_x     <= put_x;
        pend_y     <= put_y;
        pend_close <= put_close;
        pend_valid <= 1'b1;
      end
      if (do_flush) begin
        out_x      <= pend_x;
        out_y      <= pend_y;
        out_close  <= pend_close;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_close;
  assign m_axis_tlast  = out_last;

  // Checks
  `CBF_ASSERT_NOW(a_idle_no_pending, s_axis_tready, !pend_valid, "point left pending while idle")
  `CBF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `CBF_ASSERT_NOW(a_rootdiv_owner, rd_stat.busy, (state == ST_ROOT) || (state == ST_CDIV) || (state == ST_TDIV), "root/divide unit busy outside its states")

endmodule

// ===== bench/cubic_bezier_flattener_tb.sv =====
// Self-checking testbench for the cubic Bezier path flattener.
module cubic_bezier_flattener_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 20000;  // cycles without any transaction
  localparam int SETTLE_WAIT  = 2500;   // longest silent cubic plus margin
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASE_ITEMS  = 51;

  typedef struct {
    cbf_pkg::cmd_kind_t kind;
    logic signed [31:0] ex, ey, c1x, c1y, c2x, c2y;
    logic               path_end;
  } command_t;

  typedef struct {
    logic signed [31:0] x, y;
    logic               last, closing;
  } point_t;

  // Directed row: typed rows carry the expected result count (0 or 1 point)
  typedef struct {
    command_t    cmd;
    bit          typed;
    int          n_pts;
    logic [31:0] px, py;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;   // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
  logic [1:0]   s_axis_tuser = '0;   // command_kind
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // point_x, point_y
  logic [0:0]   m_axis_tuser;        // closing_point
  logic         m_axis_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [30:0]  cfg_data = '0;

  cubic_bezier_flattener DUT (.*);

  always #5 clk = ~clk;

  // Predictor state
  logic signed [31:0] pos_x, pos_y, prev_x, prev_y, start_x, start_y;
  logic [30:0]        tol_reg;
  logic               close_reg;

  point_t expected_points[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     burst_left = 1;
  bit     hold_request = 0;

  function automatic longint edge_length(longint x0, longint y0, longint x1, longint y1);
    logic [127:0] dx, dy, sq, m2;
    logic [63:0]  lo, hi, mid;
    longint       d;
    d  = x1 - x0;
    dx = (d < 0) ? -d : d;
    d  = y1 - y0;
    dy = (d < 0) ? -d : d;
    sq = dx * dx + dy * dy;
    lo = 0;
    hi = 64'd1 << 34;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      m2  = {64'd0, mid} * {64'd0, mid};
      if (m2 <= sq) lo = mid;
      else hi = mid;
    end
    return longint'(lo);
  endfunction

  // Bernstein-weighted sum, Q1.30 weights, rounded half up, saturated
  function automatic logic signed [31:0] blend(longint w0, longint w1, longint w2,
      longint w3, longint p0, longint p1, longint p2, longint p3);
    longint sum, r;
    sum = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
    r = (sum + 64'sd536870912) >>> 30;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic emit(ref point_t run[$], input logic signed [31:0] x, y, input logic closing);
    point_t p;
    p = '{x: x, y: y, last: 1'b0, closing: closing};
    run.insert(run.size(), p);
    prev_x = x;
    prev_y = y;
  endtask

  // Points one command produces; updates the path state
  task automatic flatten_command(input command_t c, ref point_t run[$]);
    longint len, tol, n, t, u, w0, w1, w2, w3;
    logic signed [31:0] px, py;
    run = {};
    case (c.kind)
      cbf_pkg::CMD_FIRST: begin
        start_x = c.ex;
        start_y = c.ey;
        emit(run, c.ex, c.ey, 1'b0);
      end
      cbf_pkg::CMD_LINE: emit(run, c.ex, c.ey, 1'b0);
      cbf_pkg::CMD_CUBIC: begin
        len = edge_length(pos_x, pos_y, c.c1x, c.c1y)
            + edge_length(c.c1x, c.c1y, c.c2x, c.c2y)
            + edge_length(c.c2x, c.c2y, c.ex, c.ey);
        tol = tol_reg;
        if (tol == 0 || len >= cbf_pkg::MAX_SEGMENTS * tol) n = cbf_pkg::MAX_SEGMENTS;
        else n = (len + tol - 1) / tol;
        if (n < cbf_pkg::MIN_SEGMENTS) n = cbf_pkg::MIN_SEGMENTS;
        for (longint s = 1; s <= n; s++) begin
          t  = (s * 65536 + n / 2) / n;
          u  = 65536 - t;
          w0 = (u * u * u + 131072) >> 18;
          w1 = (3 * u * u * t + 131072) >> 18;
          w2 = (3 * u * t * t + 131072) >> 18;
          w3 = (t * t * t + 131072) >> 18;
          px = blend(w0, w1, w2, w3, pos_x, c.c1x, c.c2x, c.ex);
          py = blend(w0, w1, w2, w3, pos_y, c.c1y, c.c2y, c.ey);
          if (px != prev_x || py != prev_y) emit(run, px, py, 1'b0);
        end
      end
      default: ;
    endcase
    pos_x = c.ex;
    pos_y = c.ey;
    if (c.path_end && close_reg) emit(run, start_x, start_y, 1'b1);
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
  endtask

  // Offer one command, wait for its transaction, then maybe start a gap
  task automatic send_command(input command_t c, input bit typed = 0, input int n_pts = 0,
                              input logic [31:0] px = '0, input logic [31:0] py = '0);
    point_t run[$];
    point_t p;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.c2y, c.c2x, c.c1y, c.c1x, c.ey, c.ex};
    s_axis_tuser  <= c.kind;
    s_axis_tlast  <= c.path_end;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    flatten_command(c, run);
    if (typed) begin
      run = {};
      if (n_pts == 1) begin
        p = '{x: px, y: py, last: 1'b1, closing: 1'b0};
        run.insert(0, p);
      end
    end
    foreach (run[i]) expected_points.insert(expected_points.size(), run[i]);
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Stop offering and let the block go quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cbf_pkg::REG_TOLERANCE) tol_reg = value;
    else close_reg = value[0];
  endtask

  function automatic logic signed [31:0] rand_coord(int span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  // One path: mostly well formed, sometimes degenerate or broken
  task automatic send_path(ref int sent);
    command_t c;
    int       k, span, shape;
    span  = 1 << $urandom_range(8, 22);
    shape = $urandom_range(0, 9);
    k     = $urandom_range(1, 5);
    for (int i = 0; i <= k; i++) begin
      c.ex  = rand_coord(span);
      c.ey  = rand_coord(span);
      c.c1x = rand_coord(span);
      c.c1y = rand_coord(span);
      c.c2x = rand_coord(span);
      c.c2y = rand_coord(span);
      c.path_end = (i == k);
      if (i == 0) begin
        c.kind = (shape == 0) ? cbf_pkg::cmd_kind_t'($urandom_range(1, 3))
                              : cbf_pkg::CMD_FIRST;
      end else if (shape == 1) begin
        // closing onto a repeated point
        c.kind = cbf_pkg::CMD_MOVE;
        c.ex = start_x;
        c.ey = start_y;
        c.path_end = 1'b1;
      end else if (shape == 2 && $urandom_range(0, 1)) begin
        // cubic collapsed onto the current point
        c.kind = cbf_pkg::CMD_CUBIC;
        {c.ex, c.c1x, c.c2x} = {3{pos_x}};
        {c.ey, c.c1y, c.c2y} = {3{pos_y}};
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    c.kind = cbf_pkg::CMD_LINE;
          2:       c.kind = cbf_pkg::CMD_MOVE;
          3:       c.kind = cbf_pkg::CMD_FIRST;
          default: c.kind = cbf_pkg::CMD_CUBIC;
        endcase
        if (shape == 3) c.path_end = 1'($urandom_range(0, 1));
      end
      send_command(c);
      sent++;
      if (shape == 1) break;
    end
  endtask

  directed_row_t directed_rows[16] = '{
    // cubic before any first point starts from zero
    '{'{cbf_pkg::CMD_CUBIC, 32'h00040000, 32'h0, 32'h00010000, 32'h00020000, 32'h00030000,
        32'h00020000, 1'b0}, 0, 0, '0, '0},
    '{'{cbf_pkg::CMD_FIRST, 32'h7FFFFFFF, 32'h80000000, '0, '0, '0, '0, 1'b0},
      1, 1, 32'h7FFFFFFF, 32'h80000000},
    '{'{cbf_pkg::CMD_LINE, 32'h80000000, 32'h7FFFFFFF, '0, '0, '0, '0, 1'b0},
      1, 1, 32'h80000000, 32'h7FFFFFFF},
    // a repeated line end still emits
    '{'{cbf_pkg::CMD_LINE, 32'h80000000, 32'h7FFFFFFF, '0, '0, '0, '0, 1'b0},
      1, 1, 32'h80000000, 32'h7FFFFFFF},
    // full-range cubic saturates the evaluation
    '{'{cbf_pkg::CMD_CUBIC, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h80000000, 32'h80000000, 1'b0}, 0, 0, '0, '0},
    '{'{cbf_pkg::CMD_MOVE, 32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 1'b0}, 1, 0, '0, '0},
    '{'{cbf_pkg::CMD_MOVE, 32'h00010000, 32'h00010000, '0, '0, '0, '0, 1'b1},
      1, 0, '0, '0},
    '{'{cbf_pkg::CMD_FIRST, 32'h00010000, 32'h00010000, '0, '0, '0, '0, 1'b0},
      1, 1, 32'h00010000, 32'h00010000},
    // cubic with no new point emits nothing
    '{'{cbf_pkg::CMD_CUBIC, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
        32'h00010000, 32'h00010000, 1'b0}, 1, 0, '0, '0},
    // tiny cubic held at the minimum segment count
    '{'{cbf_pkg::CMD_CUBIC, 32'h00010004, 32'h00010000, 32'h00010000, 32'h00010004,
        32'h00010002, 32'h00010004, 1'b0}, 0, 0, '0, '0},
    '{'{cbf_pkg::CMD_CUBIC, 32'h000A0000, 32'h00010000, 32'h00040000, 32'h00070000,
        32'h00080000, 32'hFFFC0000, 1'b0}, 0, 0, '0, '0},
    '{'{cbf_pkg::CMD_LINE, 32'hFFFFFFFF, 32'hFFFFFFFF, '0, '0, '0, '0, 1'b0},
      1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{'{cbf_pkg::CMD_CUBIC, 32'h0, 32'h0, 32'h00020000, 32'h0, 32'h0, 32'h00020000, 1'b1},
      0, 0, '0, '0},
    '{'{cbf_pkg::CMD_FIRST, 32'h0, 32'h0, '0, '0, '0, '0, 1'b0}, 1, 1, 32'h0, 32'h0},
    '{'{cbf_pkg::CMD_LINE, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
        32'hAAAAAAAA, 32'h55555555, 1'b0}, 1, 1, 32'h55555555, 32'hAAAAAAAA},
    '{'{cbf_pkg::CMD_LINE, 32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
        32'h55555555, 32'hAAAAAAAA, 1'b1}, 1, 1, 32'hAAAAAAAA, 32'h55555555}
  };

  // Result checker: transaction completes at the next rising edge
  always @(negedge clk) begin
    point_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h", m_axis_tdata[31:0], m_axis_tdata[63:32]);
      end else begin
        e = expected_points.pop_front();
        if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
            m_axis_tlast !== e.last || m_axis_tuser[0] !== e.closing) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"point mismatch: exp x=%h y=%h last=%b close=%b, ",
                      "got x=%h y=%h last=%b close=%b"},
                     e.x, e.y, e.last, e.closing, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tlast, m_axis_tuser[0]);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Receiver: stall patterns plus one long hold-off on request
  initial begin
    int mode, len;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 50);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ~m_axis_tready;
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    int sent;
    pos_x = 0; pos_y = 0; prev_x = 0; prev_y = 0; start_x = 0; start_y = 0;
    tol_reg = 31'd65536;
    close_reg = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].n_pts,
                   directed_rows[i].px, directed_rows[i].py);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(cbf_pkg::REG_TOLERANCE, 31'd0);
          write_reg(cbf_pkg::REG_CLOSE, 31'd1);
        end
        1: begin
          write_reg(cbf_pkg::REG_TOLERANCE, 31'h7FFFFFFF);
          write_reg(cbf_pkg::REG_CLOSE, 31'd1);
        end
        2: begin
          write_reg(cbf_pkg::REG_TOLERANCE, 31'd1);
          write_reg(cbf_pkg::REG_CLOSE, 31'd0);
        end
        default: begin
          write_reg(cbf_pkg::REG_TOLERANCE, 31'($urandom_range(32'h1000, 32'h100000)));
          write_reg(cbf_pkg::REG_CLOSE, 31'd1);
          hold_request = 1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) send_path(sent);
      drain();
    end

    if (mismatches == 0 && expected_points.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cbf_pkg.sv
sv/cbf_mac.sv
sv/cbf_rootdiv.sv
sv/cubic_bezier_flattener.sv
bench/cubic_bezier_flattener_tb.sv
